[src/tseq_pkg.sv]
// Package with the types and constants shared by the timestamp-sorted event queue.
package tseq_pkg;

	localparam int TIME_W = 32;
	localparam int KIND_W = 8;
	localparam int SUB_W  = 8;
	localparam int PAY_W  = 32;
	localparam int POS_W  = 6;
	localparam int IDX_W  = 7;
	localparam int REQ_W  = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 3'd0,
		REQ_APPEND = 3'd1,
		REQ_INSERT = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_READ   = 3'd4,
		REQ_POP    = 3'd5,
		REQ_SEEK   = 3'd6
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_INSERT,
		S_REMOVE,
		S_SHOW,
		S_POP,
		S_SEEK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TIME_W-1:0] event_time;
		logic [KIND_W-1:0] event_kind;
		logic [SUB_W-1:0]  event_subtype;
		logic [PAY_W-1:0]  event_payload;
		logic [POS_W-1:0]  position;
		logic [TIME_W-1:0] query_time;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [TIME_W-1:0] out_time;
		logic [KIND_W-1:0] out_kind;
		logic [SUB_W-1:0]  out_subtype;
		logic [PAY_W-1:0]  out_payload;
		logic [IDX_W-1:0]  out_index;
		logic [IDX_W-1:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [KIND_W-1:0] kind;
		logic [SUB_W-1:0]  subtype;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

[src/tseq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[src/tseq_cmp.sv]
// Shared timestamp comparator used by the append check, the insert shift and the pop and seek searches.
module tseq_cmp
	import tseq_pkg::*;
(
	input  logic [TIME_W-1:0] stored,
	input  logic [TIME_W-1:0] key,
	output cmp_t              result
);

	assign result.lt = stored < key;
	assign result.eq = stored == key;

endmodule

[src/timestamp_sorted_event_queue_top.sv]
// Top level of the timestamp-sorted event queue: sequencer, entry store and response register.
// Clear, unknown requests, a full insert, a bad index and a pop past the end go straight to the
// finish state; append, read and any other pop first read one entry from the store; insert and
// remove move the entries one at a time, and seek steps from the first entry to the new cursor.
// Entry moves share one RAM read and one write port; a new request is taken the cycle after the
// response is registered. Reset clears the count and cursor.
module timestamp_sorted_event_queue_top
	import tseq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   cursor_q, cursor_d;
	logic [CW-1:0]   ptr_q, ptr_d;
	req_t            req_q;
	rsp_t            res_q, res_d;
	rsp_t            rsp_q;
	rsp_t            rsp_d;
	logic            rsp_valid_q;
	logic            rsp_load;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic [AW-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_bits;
	entry_t          rd_entry;
	entry_t          new_entry;
	logic [TIME_W-1:0] key;
	cmp_t            cmp;
	logic            pos_bad;
	logic [CW-1:0]   pos_c;

	tseq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_bits)
	);

	assign rd_entry = entry_t'(rd_bits);
	assign key = (state_q == S_POP || state_q == S_SEEK) ? req_q.query_time : req_q.event_time;

	tseq_cmp u_cmp (
		.stored(rd_entry.stamp),
		.key   (key),
		.result(cmp)
	);

	assign new_entry = '{stamp: req_q.event_time, kind: req_q.event_kind,
		subtype: req_q.event_subtype, payload: req_q.event_payload};
	assign pos_bad = CMPW'(req.position) >= CMPW'(count_q);
	assign pos_c   = CW'(req.position);

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		ptr_d    = ptr_q;
		res_d    = res_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = AW'(ptr_q);
		wr_data  = rd_entry;
		rsp_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					res_d = '0;
					case (req.req_type)
						REQ_CLEAR: begin
							count_d = '0;
							state_d = S_FIN;
						end
						REQ_APPEND: begin
							rd_addr = AW'(count_q - 1'b1);
							state_d = S_APPEND;
						end
						REQ_INSERT: begin
							if (count_q >= CW'(DEPTH)) begin
								res_d.status = ST_FULL;
								state_d      = S_FIN;
							end else begin
								ptr_d   = count_q;
								rd_addr = AW'(count_q - 1'b1);
								state_d = S_INSERT;
							end
						end
						REQ_REMOVE: begin
							if (pos_bad) begin
								res_d.status = ST_BAD;
								state_d      = S_FIN;
							end else begin
								ptr_d   = pos_c + 1'b1;
								rd_addr = AW'(pos_c + 1'b1);
								state_d = S_REMOVE;
							end
						end
						REQ_READ: begin
							if (pos_bad) begin
								res_d.status = ST_BAD;
								state_d      = S_FIN;
							end else begin
								rd_addr         = AW'(pos_c);
								res_d.out_index = IDX_W'(pos_c);
								state_d         = S_SHOW;
							end
						end
						REQ_POP: begin
							res_d.out_index = IDX_W'(cursor_q);
							if (cursor_q >= count_q) begin
								res_d.status = ST_NONE;
								state_d      = S_FIN;
							end else begin
								rd_addr = AW'(cursor_q);
								state_d = S_POP;
							end
						end
						REQ_SEEK: begin
							ptr_d   = '0;
							rd_addr = '0;
							state_d = S_SEEK;
						end
						default: begin
							res_d.status = ST_BAD;
							state_d      = S_FIN;
						end
					endcase
				end
			end
			S_APPEND: begin
				if (count_q != '0 && !cmp.lt && !cmp.eq) begin
					res_d.status = ST_BAD;
				end else if (count_q >= CW'(DEPTH)) begin
					res_d.status = ST_FULL;
				end else begin
					wr_en           = 1'b1;
					wr_addr         = AW'(count_q);
					wr_data         = new_entry;
					res_d.out_index = IDX_W'(count_q);
					count_d         = count_q + 1'b1;
				end
				state_d = S_FIN;
			end
			S_INSERT: begin
				wr_en = 1'b1;
				if (ptr_q == '0 || cmp.lt || cmp.eq) begin
					wr_data         = new_entry;
					res_d.out_index = IDX_W'(ptr_q);
					count_d         = count_q + 1'b1;
					state_d         = S_FIN;
				end else begin
					ptr_d   = ptr_q - 1'b1;
					rd_addr = AW'(ptr_q - CW'(2));
				end
			end
			S_REMOVE: begin
				if (ptr_q >= count_q) begin
					count_d = count_q - 1'b1;
					state_d = S_FIN;
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(ptr_q - 1'b1);
					ptr_d   = ptr_q + 1'b1;
					rd_addr = AW'(ptr_q + 1'b1);
				end
			end
			S_SHOW: begin
				res_d.out_time    = rd_entry.stamp;
				res_d.out_kind    = rd_entry.kind;
				res_d.out_subtype = rd_entry.subtype;
				res_d.out_payload = rd_entry.payload;
				state_d           = S_FIN;
			end
			S_POP: begin
				if (cmp.lt || cmp.eq) begin
					res_d.out_time    = rd_entry.stamp;
					res_d.out_kind    = rd_entry.kind;
					res_d.out_subtype = rd_entry.subtype;
					res_d.out_payload = rd_entry.payload;
					cursor_d          = cursor_q + 1'b1;
				end else begin
					res_d.status = ST_NONE;
				end
				state_d = S_FIN;
			end
			S_SEEK: begin
				if (ptr_q >= count_q || !cmp.lt) begin
					cursor_d        = ptr_q;
					res_d.out_index = IDX_W'(ptr_q);
					state_d         = S_FIN;
				end else begin
					ptr_d   = ptr_q + 1'b1;
					rd_addr = AW'(ptr_q + 1'b1);
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_d             = res_q;
		rsp_d.entry_count = IDX_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Entry count exceeds the store depth.");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CW'(DEPTH))
		else $error("Playback cursor exceeds the store depth.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1
			|| count_q == '0))
		else $error("Entry count changed by more than one in a transaction.");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_APPEND || state_q == S_INSERT || state_q == S_REMOVE))
		else $error("Store written outside an editing step.");

	a_cursor_move: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != $past(cursor_q) |->
			(($past(state_q) == S_POP && cursor_q == $past(cursor_q) + 1'b1)
			|| $past(state_q) == S_SEEK))
		else $error("Playback cursor moved outside pop or seek.");

endmodule
